// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the sharpening filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SHP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/shp_pkg.sv -----
// Types and constants shared by the 3x3 sharpening filter.
package shp_pkg;

  localparam int PIX_W     = 8;
  localparam int CNT_W     = 11;
  localparam int DIM_W     = 12;
  localparam int COEFF_W   = 16;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int MIN_DIM   = 3;
  localparam int MAX_HEIGHT = 2048;

  // Register reset values
  localparam logic [DIM_W-1:0]   LINE_WIDTH_RST   = 12'd640;
  localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = 12'd480;
  localparam logic [COEFF_W-1:0] CORNER_RST       = 16'hF9F0; // -1552
  localparam logic [COEFF_W-1:0] EDGE_RST         = 16'hF86D; // -1939
  localparam logic [COEFF_W-1:0] CENTER_RST       = 16'h768B; // 30347

  // Register word indexes on the configuration port
  typedef enum logic [2:0] {
    REG_LINE_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_CORNER       = 3'd2,
    REG_EDGE         = 3'd3,
    REG_CENTER       = 3'd4
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;

  // One window column, top to bottom
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } win_col_t;

  // Line buffer port strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } lb_ctrl_t;

endpackage

// ----- rtl/shp_cell.sv -----
// One window cell: holds a pixel column and hands it on at each shift.
module shp_cell
  import shp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  win_col_t           col_i,
  output win_col_t           col_o,
  output logic [PIX_W:0]     pair_sum_o
);

  win_col_t col_q, col_d;

  // Load the neighbour's column on shift, hold otherwise
  always_comb begin
    col_d = shift_i ? col_i : col_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  // Top plus bottom: corners of a side column, edges of the centre column
  assign col_o      = col_q;
  assign pair_sum_o = {1'b0, col_q.top} + {1'b0, col_q.bot};

endmodule

// ----- rtl/shp_linebuf.sv -----
// Two line buffers with registered read and write-to-read forwarding.
module shp_linebuf
  import shp_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk_i,
  input  lb_ctrl_t      ctrl_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic [AW-1:0] wr_addr_i,
  input  pix_t          wr_upper_i,
  input  pix_t          wr_middle_i,
  output pix_t          upper_o,
  output pix_t          middle_o
);

  pix_t upper_mem  [DEPTH];
  pix_t middle_mem [DEPTH];

  pix_t rd_upper_q, rd_middle_q;
  pix_t fwd_upper_q, fwd_middle_q;
  logic hit_q;

  // Write the beat leaving the first stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      upper_mem[wr_addr_i]  <= wr_upper_i;
      middle_mem[wr_addr_i] <= wr_middle_i;
    end
  end

  // Read for the accepted beat; catch a write to the same entry in that cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_upper_q   <= upper_mem[rd_addr_i];
      rd_middle_q  <= middle_mem[rd_addr_i];
      hit_q        <= ctrl_i.wr_en && (wr_addr_i == rd_addr_i);
      fwd_upper_q  <= wr_upper_i;
      fwd_middle_q <= wr_middle_i;
    end
  end

  assign upper_o  = hit_q ? fwd_upper_q  : rd_upper_q;
  assign middle_o = hit_q ? fwd_middle_q : rd_middle_q;

endmodule

// ----- rtl/sharpen_3x3_convolution.sv -----
// A result beat passes through stages A, B, C and O after its pixel beat is accepted.
// Throughput: one pixel per clock while the result stream takes beats; each stage moves on
// when the next is free, so the input keeps flowing while a result waits in the output register, until the stages fill.
// The line buffer read port and the three-tap multiply stage set the pace.
// Reset clears counters, stage valids and the window and restores register
// defaults; line buffer contents are left as they are.
`include "assert_macros.svh"

module sharpen_3x3_convolution
  import shp_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int COEFF_FRAC = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // pixel input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] pixel_in
  input  logic               s_axis_tuser,   // [0] frame_start
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // [7:0] pixel_out, [18:8] out_row,
                                             // [29:19] out_col, [31:30] zero
  output logic               m_axis_tlast,   // frame_done
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW  = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
  localparam int CS_W = PIX_W + 2;              // sum of four pixels
  localparam int PW  = CS_W + 1 + COEFF_W;      // product width
  localparam int SW  = PW + 2;                  // three-product sum
  localparam int QW  = SW - COEFF_FRAC;

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [DIM_W-1:0]          line_width_q, frame_height_q;
  logic signed [COEFF_W-1:0] corner_q, edge_q, center_q;
  logic                      cfg_wr;
  cfg_reg_e                  cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LINE_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      corner_q       <= CORNER_RST;
      edge_q         <= EDGE_RST;
      center_q       <= CENTER_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_LINE_WIDTH:   line_width_q   <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[DIM_W-1:0];
        REG_CORNER:       corner_q       <= pwdata[COEFF_W-1:0];
        REG_EDGE:         edge_q         <= pwdata[COEFF_W-1:0];
        REG_CENTER:       center_q       <= pwdata[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, coefficients sign extended
  always_comb begin
    unique case (cfg_sel)
      REG_LINE_WIDTH:   prdata = APB_DW'(line_width_q);
      REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_q);
      REG_CORNER:       prdata = APB_DW'(corner_q);
      REG_EDGE:         prdata = APB_DW'(edge_q);
      REG_CENTER:       prdata = APB_DW'(center_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Stage handshake
  logic vA_q, vB_q, vC_q, vO_q;
  logic mvA, mvB, mvC, mvO, accept;

  assign mvO    = vO_q && m_axis_tready;
  assign mvC    = vC_q && (!vO_q || mvO);
  assign mvB    = vB_q && (!vC_q || mvC);
  assign mvA    = vA_q && (!vB_q || mvB);
  assign s_axis_tready = !vA_q || mvA;
  assign accept = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------
  // Raster position
  logic [CNT_W-1:0] col_q, col_d, row_q, row_d, col_cur, row_cur;
  logic [AW-1:0]    addr_q, addr_d, addr_cur;
  logic [CW-1:0]    lw_ext, w_eff, col_inc;
  logic [DIM_W-1:0] h_eff, row_inc;
  logic             col_wrap, row_wrap, emit, done;

  always_comb begin
    // Clamp the frame geometry
    lw_ext = CW'(line_width_q);
    if (lw_ext < CW'(MIN_DIM)) begin
      w_eff = CW'(MIN_DIM);
    end else if (lw_ext > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = lw_ext;
    end
    if (frame_height_q < DIM_W'(MIN_DIM)) begin
      h_eff = DIM_W'(MIN_DIM);
    end else if (frame_height_q > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height_q;
    end

    // Frame start forces the origin for this beat
    col_cur  = s_axis_tuser ? '0 : col_q;
    row_cur  = s_axis_tuser ? '0 : row_q;
    addr_cur = s_axis_tuser ? '0 : addr_q;

    emit     = (row_cur >= CNT_W'(2)) && (col_cur >= CNT_W'(2));
    col_inc  = CW'(col_cur) + CW'(1);
    row_inc  = DIM_W'(row_cur) + DIM_W'(1);
    col_wrap = col_inc >= w_eff;
    row_wrap = row_inc >= h_eff;
    done     = col_wrap && row_wrap;

    // Advance the position
    col_d = col_q;
    row_d = row_q;
    addr_d = addr_q;
    if (accept) begin
      col_d = col_wrap ? '0 : col_inc[CNT_W-1:0];
      if (col_wrap) begin
        row_d = row_wrap ? '0 : row_inc[CNT_W-1:0];
      end else begin
        row_d = row_cur;
      end
      if (col_d == '0 || addr_cur == AW'(MAX_WIDTH - 1)) begin
        addr_d = '0;
      end else begin
        addr_d = addr_cur + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      addr_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      addr_q <= addr_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: pixel captured, line buffers read
  pix_t             a_px_q;
  logic [CNT_W-1:0] a_row_q, a_col_q;
  logic [AW-1:0]    a_addr_q;
  logic             a_emit_q, a_done_q;
  pix_t             lb_upper, lb_middle;
  lb_ctrl_t         lb_ctrl;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_px_q   <= s_axis_tdata;
      a_row_q  <= row_cur - CNT_W'(1);
      a_col_q  <= col_cur - CNT_W'(1);
      a_addr_q <= addr_cur;
      a_emit_q <= emit;
      a_done_q <= done;
    end
  end

  assign lb_ctrl.rd_en = accept;
  assign lb_ctrl.wr_en = mvA;

  shp_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_linebuf (
    .clk_i       (clk_i),
    .ctrl_i      (lb_ctrl),
    .rd_addr_i   (addr_cur),
    .wr_addr_i   (a_addr_q),
    .wr_upper_i  (lb_middle),
    .wr_middle_i (a_px_q),
    .upper_o     (lb_upper),
    .middle_o    (lb_middle)
  );

  // Window: a chain of two column cells fed by the newest column
  win_col_t        new_col, left_col, centre_col;
  logic [PIX_W:0]  left_pair, centre_pair;

  assign new_col = '{top: lb_upper, mid: lb_middle, bot: a_px_q};

  shp_cell u_cell_centre (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_i    (mvA),
    .col_i      (new_col),
    .col_o      (centre_col),
    .pair_sum_o (centre_pair)
  );

  shp_cell u_cell_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_i    (mvA),
    .col_i      (centre_col),
    .col_o      (left_col),
    .pair_sum_o (left_pair)
  );

  // ---------------------------------------------------------------------
  // Stage B: grouped tap sums
  logic [CS_W-1:0]  b_corners_q, b_edges_q;
  pix_t             b_centre_q;
  logic [CNT_W-1:0] b_row_q, b_col_q;
  logic             b_done_q;

  always_ff @(posedge clk_i) begin
    if (mvA) begin
      b_corners_q <= CS_W'(left_pair) + CS_W'(lb_upper) + CS_W'(a_px_q);
      b_edges_q   <= CS_W'(left_col.mid) + CS_W'(centre_pair) + CS_W'(lb_middle);
      b_centre_q  <= centre_col.mid;
      b_row_q     <= a_row_q;
      b_col_q     <= a_col_q;
      b_done_q    <= a_done_q;
    end
  end

  // Stage C: one multiply per coefficient
  logic signed [PW-1:0] c_prod_cn_q, c_prod_ed_q, c_prod_ce_q;
  logic [CNT_W-1:0]     c_row_q, c_col_q;
  logic                 c_done_q;
  logic signed [CS_W:0] b_cn_s, b_ed_s, b_ce_s;

  assign b_cn_s = $signed({1'b0, b_corners_q});
  assign b_ed_s = $signed({1'b0, b_edges_q});
  assign b_ce_s = $signed({1'b0, CS_W'(b_centre_q)});

  always_ff @(posedge clk_i) begin
    if (mvB) begin
      c_prod_cn_q <= b_cn_s * corner_q;
      c_prod_ed_q <= b_ed_s * edge_q;
      c_prod_ce_q <= b_ce_s * center_q;
      c_row_q     <= b_row_q;
      c_col_q     <= b_col_q;
      c_done_q    <= b_done_q;
    end
  end

  // Stage O: add, truncate and saturate into the output register
  logic signed [SW-1:0] sum;
  logic [QW-1:0]        sum_int;
  pix_t                 pix_sat, o_pix_q;
  logic [CNT_W-1:0]     o_row_q, o_col_q;
  logic                 o_done_q;

  always_comb begin
    sum     = SW'(c_prod_cn_q) + SW'(c_prod_ed_q) + SW'(c_prod_ce_q);
    sum_int = sum[SW-1:COEFF_FRAC];
    if (sum[SW-1] || sum == '0) begin
      pix_sat = '0;
    end else if (|sum_int[QW-1:PIX_W]) begin
      pix_sat = '1;
    end else begin
      pix_sat = sum_int[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mvC) begin
      o_pix_q  <= pix_sat;
      o_row_q  <= c_row_q;
      o_col_q  <= c_col_q;
      o_done_q <= c_done_q;
    end
  end

  // Stage valids; beats without a full window (border positions) drop out after stage A
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vA_q <= 1'b0;
      vB_q <= 1'b0;
      vC_q <= 1'b0;
      vO_q <= 1'b0;
    end else begin
      if (accept || mvA) vA_q <= accept;
      if (mvA || mvB)    vB_q <= mvA && a_emit_q;
      if (mvB || mvC)    vC_q <= mvB;
      if (mvC || mvO)    vO_q <= mvC;
    end
  end

  assign m_axis_tvalid = vO_q;
  assign m_axis_tdata  = {2'b00, o_col_q, o_row_q, o_pix_q};
  assign m_axis_tlast  = o_done_q;

  // ---------------------------------------------------------------------
  `SHP_ASSERT_NEXT(a_sum_hold, clk_i, rst_ni, vB_q && !mvB, vB_q && $stable(b_corners_q))
  `SHP_ASSERT_NEXT(a_emit_fwd, clk_i, rst_ni, mvA && a_emit_q, vB_q)
  `SHP_ASSERT_IMPL(a_no_border, clk_i, rst_ni, vO_q, (o_row_q != '0) && (o_col_q != '0))

endmodule
